/* sv/ppcs_pkg.sv */
// shared types, constants and clock table for the panel power and pixel clock sequencer
// no dependencies
package ppcs_pkg;

    localparam int NUM_CLOCKS = 9;
    localparam int TABLE_LEN  = 9;
    localparam int NUM_SEARCH = (NUM_CLOCKS < TABLE_LEN) ? NUM_CLOCKS : TABLE_LEN;

    localparam int KHZ_W     = 17;
    localparam int REQ_W     = 18;
    localparam int CODE_W    = 4;
    localparam int DELAY_W   = 16;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int IDX_W     = 4;

    localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd10;
    localparam logic [CODE_W-1:0]  CODE_RESET  = 4'ha;

    // line bit positions
    localparam int LINE_LVDS  = 0;
    localparam int LINE_PANEL = 1;
    localparam int LINE_BLOFF = 2;
    localparam logic [2:0] LINES_RESET = 3'b100;

    localparam logic [KHZ_W-1:0] CLK_KHZ [TABLE_LEN] = '{
        17'd6750, 17'd13500, 17'd27000, 17'd29700, 17'd37125,
        17'd54000, 17'd59400, 17'd74250, 17'd120000
    };
    localparam logic [CODE_W-1:0] CLK_CODE [TABLE_LEN] = '{
        4'ha, 4'h9, 4'h8, 4'h7, 4'h6, 4'h5, 4'h4, 4'h3, 4'hb
    };

    typedef enum logic [2:0] {
        KIND_TICK      = 3'd0,
        KIND_PANEL_ON  = 3'd1,
        KIND_PANEL_OFF = 3'd2,
        KIND_BL_ON     = 3'd3,
        KIND_BL_OFF    = 3'd4,
        KIND_SET_CLK   = 3'd5,
        KIND_QUERY     = 3'd6,
        KIND_SPARE     = 3'd7
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BUSY    = 2'd1,
        ST_INEXACT = 2'd2
    } status_t;

    localparam logic [PADDR_W-3:0] REG_DELAY = 1'b0;

    typedef struct packed {
        logic [2:0]       kind;
        logic [REQ_W-1:0] clock_khz;
    } item_t;

    typedef struct packed {
        logic              lvds_on;
        logic              panel_pwr;
        logic              bl_dark;
        logic [CODE_W-1:0] clock_code;
        logic [KHZ_W-1:0]  nearest_clock_khz;
        logic [1:0]        status;
        logic              busy_res;
    } result_t;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [KHZ_W-1:0]  khz;
        logic              exact;
    } match_t;

endpackage

/* sv/ppcs_apb.sv */
// apb configuration register for the sequencer: holds delay_ticks
// depends on ppcs_pkg
module ppcs_apb (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ppcs_pkg::PADDR_W-1:0]     paddr,
    input  logic [ppcs_pkg::PDATA_W-1:0]     pwdata,
    output logic [ppcs_pkg::PDATA_W-1:0]     prdata,
    output logic                             pready,
    output logic [ppcs_pkg::DELAY_W-1:0]     delay_ticks
);
    import ppcs_pkg::*;

    logic [DELAY_W-1:0] delay_reg;
    logic [DELAY_W-1:0] delay_next;
    logic               hit;

    assign hit = (paddr[PADDR_W-1:2] == REG_DELAY);

    always_comb
    begin
        delay_next = delay_reg;
        if (psel && penable && pwrite && hit)
        begin
            delay_next = pwdata[DELAY_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg <= DELAY_RESET;
        end
        else
        begin
            delay_reg <= delay_next;
        end
    end

    assign prdata      = hit ? {{(PDATA_W-DELAY_W){1'b0}}, delay_reg} : '0;
    assign pready      = 1'b1;
    assign delay_ticks = delay_reg;

endmodule

/* sv/ppcs_clk_match.sv */
// nearest supported pixel clock lookup by midpoint compares against the table
// depends on ppcs_pkg
module ppcs_clk_match (
    input  logic [ppcs_pkg::REQ_W-1:0] clock_khz,
    output ppcs_pkg::match_t           match
);
    import ppcs_pkg::*;

    logic [REQ_W:0]   req2;
    logic [IDX_W-1:0] idx;

    assign req2 = {clock_khz, 1'b0};

    // table is ascending: step past each midpoint that the request lies strictly above
    always_comb
    begin
        idx = '0;
        for (int i = 0; i < NUM_SEARCH - 1; i++)
        begin
            if (req2 > ({2'b00, CLK_KHZ[i]} + {2'b00, CLK_KHZ[i+1]}))
            begin
                idx = IDX_W'(i + 1);
            end
        end
    end

    always_comb
    begin
        match.code  = CLK_CODE[idx];
        match.khz   = CLK_KHZ[idx];
        match.exact = ({1'b0, CLK_KHZ[idx]} == clock_khz);
    end

endmodule

/* sv/ppcs_core.sv */
// power sequencing state, clock code and result register
// depends on ppcs_pkg
module ppcs_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         fire,
    input  ppcs_pkg::item_t              item,
    input  ppcs_pkg::match_t             match,
    input  logic [ppcs_pkg::DELAY_W-1:0] delay_ticks,
    input  logic                         result_ready,
    output logic                         result_valid,
    output ppcs_pkg::result_t            result
);
    import ppcs_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE       = 2'd0,
        PH_PANEL_UP   = 2'd1,
        PH_LVDS_UP    = 2'd2,
        PH_PANEL_DOWN = 2'd3
    } phase_t;

    typedef struct packed {
        phase_t             phase;
        logic [DELAY_W-1:0] count;
        logic [2:0]         lines;
    } seq_t;

    seq_t              seq_reg;
    seq_t              seq_next;
    logic [CODE_W-1:0] code_reg;
    logic [CODE_W-1:0] code_next;
    logic              valid_reg;
    logic              valid_next;
    result_t           result_reg;
    result_t           result_next;
    logic [KHZ_W-1:0]  nearest;
    status_t           status;

    function automatic logic [2:0] apply_step(phase_t ph, logic [2:0] lines);
        logic [2:0] l;
        l = lines;
        unique case (ph)
            PH_PANEL_UP:   l[LINE_PANEL] = 1'b1;
            PH_LVDS_UP:    l[LINE_LVDS]  = 1'b1;
            PH_PANEL_DOWN: l[LINE_PANEL] = 1'b0;
            default:       l = lines;
        endcase
        return l;
    endfunction

    function automatic phase_t next_after(phase_t ph, logic [2:0] lines);
        phase_t p;
        p = PH_IDLE;
        if (ph == PH_PANEL_UP && !lines[LINE_LVDS])
        begin
            p = PH_LVDS_UP;
        end
        return p;
    endfunction

    // a zero delay runs the pending steps at once; at most two steps chain
    function automatic seq_t start_wait(phase_t ph, seq_t s, logic [DELAY_W-1:0] dly);
        seq_t   r;
        phase_t p;
        r       = s;
        r.phase = PH_IDLE;
        p       = ph;
        for (int i = 0; i < 2; i++)
        begin
            if (p != PH_IDLE)
            begin
                if (dly != '0)
                begin
                    r.phase = p;
                    r.count = dly;
                    p       = PH_IDLE;
                end
                else
                begin
                    r.lines = apply_step(p, r.lines);
                    p       = next_after(p, r.lines);
                end
            end
        end
        return r;
    endfunction

    always_comb
    begin
        seq_t s;
        s         = seq_reg;
        code_next = code_reg;
        nearest   = '0;
        status    = ST_OK;
        if (item.kind != KIND_TICK && item.kind != KIND_SPARE && seq_reg.phase != PH_IDLE)
        begin
            status = ST_BUSY;
        end
        else
        begin
            unique case (item.kind)
                KIND_TICK:
                begin
                    if (seq_reg.phase != PH_IDLE)
                    begin
                        if (seq_reg.count > DELAY_W'(1))
                        begin
                            s.count = seq_reg.count - DELAY_W'(1);
                        end
                        else
                        begin
                            s.count = '0;
                            s.lines = apply_step(seq_reg.phase, seq_reg.lines);
                            s = start_wait(next_after(seq_reg.phase, s.lines), s, delay_ticks);
                        end
                    end
                end
                KIND_PANEL_ON:
                begin
                    if (!seq_reg.lines[LINE_PANEL])
                    begin
                        s.lines[LINE_LVDS] = 1'b0;
                        s = start_wait(PH_PANEL_UP, s, delay_ticks);
                    end
                    else if (!seq_reg.lines[LINE_LVDS])
                    begin
                        s = start_wait(PH_LVDS_UP, s, delay_ticks);
                    end
                end
                KIND_PANEL_OFF:
                begin
                    s.lines[LINE_LVDS] = 1'b0;
                    if (seq_reg.lines[LINE_PANEL])
                    begin
                        s = start_wait(PH_PANEL_DOWN, s, delay_ticks);
                    end
                end
                KIND_BL_ON:  s.lines[LINE_BLOFF] = 1'b0;
                KIND_BL_OFF: s.lines[LINE_BLOFF] = 1'b1;
                KIND_SET_CLK:
                begin
                    nearest = match.khz;
                    if (match.exact)
                    begin
                        code_next = match.code;
                    end
                    else
                    begin
                        status = ST_INEXACT;
                    end
                end
                KIND_QUERY: nearest = match.khz;
                default:    s = seq_reg;
            endcase
        end
        seq_next = s;

        result_next.lvds_on           = s.lines[LINE_LVDS];
        result_next.panel_pwr         = s.lines[LINE_PANEL];
        result_next.bl_dark           = s.lines[LINE_BLOFF];
        result_next.clock_code        = code_next;
        result_next.nearest_clock_khz = nearest;
        result_next.status            = status;
        result_next.busy_res          = (s.phase != PH_IDLE);

        valid_next = fire || (valid_reg && !result_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg.phase <= PH_IDLE;
            seq_reg.count <= '0;
            seq_reg.lines <= LINES_RESET;
            code_reg      <= CODE_RESET;
            valid_reg     <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (fire)
            begin
                seq_reg  <= seq_next;
                code_reg <= code_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = valid_reg;
    assign result       = result_reg;

endmodule

/* sv/panel_power_and_pixel_clock_sequencer.sv */
// top level of the panel power and pixel clock sequencer: input register and pipeline control
// depends on ppcs_pkg, ppcs_apb, ppcs_clk_match and ppcs_core
//
// usage
// item channel (item_valid/item_ready/item) carries one command or tick per transaction;
// result channel (result_valid/result_ready/result) returns exactly one result per item,
// holding the panel lines, clock code, nearest clock, status and busy flag after the update.
// an item is captured in an input register and then processed into the result register,
// which drives result_valid; while a result waits unread, the item stays in the input register.
// throughput is one item per cycle while results are taken; the input register and result
// register form a two-entry pipeline so a new item is taken while a finished result waits.
// if the receiver stalls, the pipeline fills and item_ready drops after two transactions.
// the apb port holds delay_ticks at byte address 0; pready is always high.
// reset: backlight dark, panel and lvds off, clock code 0x0a, no wait running,
// delay_ticks 10; the pipeline is empty.
module panel_power_and_pixel_clock_sequencer (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    output logic                         item_ready,
    input  ppcs_pkg::item_t              item,
    output logic                         result_valid,
    input  logic                         result_ready,
    output ppcs_pkg::result_t            result,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ppcs_pkg::PADDR_W-1:0] paddr,
    input  logic [ppcs_pkg::PDATA_W-1:0] pwdata,
    output logic [ppcs_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);
    import ppcs_pkg::*;

    item_t              item_reg;
    logic               item_valid_reg;
    logic               item_valid_next;
    logic               advance;
    logic               fire;
    logic [DELAY_W-1:0] delay_ticks;
    match_t             match;

    assign advance    = !result_valid || result_ready;
    assign fire       = item_valid_reg && advance;
    assign item_ready = !item_valid_reg || advance;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (item_ready)
        begin
            item_valid_next = item_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg <= item;
        end
    end

    ppcs_apb u_apb (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .delay_ticks (delay_ticks)
    );

    ppcs_clk_match u_clk_match (
        .clock_khz (item_reg.clock_khz),
        .match     (match)
    );

    ppcs_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (fire),
        .item         (item_reg),
        .match        (match),
        .delay_ticks  (delay_ticks),
        .result_ready (result_ready),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

/* test/ppcs_checker.sv */
// checker for the panel power and pixel clock sequencer: predicts each result and compares
// depends on ppcs_pkg; watches the item, result and apb channels of the block
module ppcs_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    input  logic                         item_ready,
    input  ppcs_pkg::item_t              item,
    input  logic                         result_valid,
    input  logic                         result_ready,
    input  ppcs_pkg::result_t            result,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ppcs_pkg::PADDR_W-1:0] paddr,
    input  logic [ppcs_pkg::PDATA_W-1:0] pwdata,
    input  logic                         pready,
    output int                           fail_count,
    output int                           outstanding
);
    import ppcs_pkg::*;

    typedef enum logic [1:0] {
        SEQ_IDLE       = 2'd0,
        SEQ_PANEL_UP   = 2'd1,
        SEQ_LVDS_UP    = 2'd2,
        SEQ_PANEL_DOWN = 2'd3
    } seq_phase_t;

    localparam logic [PADDR_W-1:0] DELAY_ADDR = {REG_DELAY, 2'b00};

    logic [2:0]         lines;
    logic [CODE_W-1:0]  pll;
    seq_phase_t         seq;
    logic [DELAY_W-1:0] wait_left;
    logic [DELAY_W-1:0] delay;
    result_t            expected_results [$];
    result_t            exp_res;
    int                 errors;

    function automatic void do_power_step(input seq_phase_t ph);
        if (ph == SEQ_PANEL_UP)
            lines[LINE_PANEL] = 1'b1;
        else if (ph == SEQ_LVDS_UP)
            lines[LINE_LVDS] = 1'b1;
        else if (ph == SEQ_PANEL_DOWN)
            lines[LINE_PANEL] = 1'b0;
    endfunction

    function automatic seq_phase_t step_after(input seq_phase_t ph);
        if (ph == SEQ_PANEL_UP && !lines[LINE_LVDS])
            return SEQ_LVDS_UP;
        return SEQ_IDLE;
    endfunction

    // zero delay runs the steps straight through
    function automatic void begin_wait(input seq_phase_t first);
        seq_phase_t ph;
        ph = first;
        seq = SEQ_IDLE;
        while (ph != SEQ_IDLE)
        begin
            if (delay != '0)
            begin
                seq = ph;
                wait_left = delay;
                return;
            end
            do_power_step(ph);
            ph = step_after(ph);
        end
    endfunction

    // the earlier table entry wins on a tie
    function automatic int nearest_entry(input logic [REQ_W-1:0] req);
        int best;
        int best_diff;
        int d;
        best = 0;
        best_diff = int'(req) - int'(CLK_KHZ[0]);
        if (best_diff < 0)
            best_diff = -best_diff;
        for (int i = 1; i < NUM_SEARCH; i++)
        begin
            d = int'(req) - int'(CLK_KHZ[i]);
            if (d < 0)
                d = -d;
            if (d < best_diff)
            begin
                best = i;
                best_diff = d;
            end
        end
        return best;
    endfunction

    function automatic result_t predict_panel_state(input item_t it);
        result_t            r;
        seq_phase_t         ph;
        int                 idx;
        logic [KHZ_W-1:0]   near;
        status_t            st;
        near = '0;
        st = ST_OK;
        if (it.kind == KIND_TICK)
        begin
            if (seq != SEQ_IDLE)
            begin
                if (wait_left > 1)
                    wait_left = wait_left - 1'b1;
                else
                begin
                    wait_left = '0;
                    ph = seq;
                    seq = SEQ_IDLE;
                    do_power_step(ph);
                    begin_wait(step_after(ph));
                end
            end
        end
        else if (it.kind <= KIND_QUERY && seq != SEQ_IDLE)
            st = ST_BUSY;
        else
        begin
            case (it.kind)
                KIND_PANEL_ON:
                begin
                    if (!lines[LINE_PANEL])
                    begin
                        lines[LINE_LVDS] = 1'b0;
                        begin_wait(SEQ_PANEL_UP);
                    end
                    else if (!lines[LINE_LVDS])
                        begin_wait(SEQ_LVDS_UP);
                end
                KIND_PANEL_OFF:
                begin
                    lines[LINE_LVDS] = 1'b0;
                    if (lines[LINE_PANEL])
                        begin_wait(SEQ_PANEL_DOWN);
                end
                KIND_BL_ON:
                    lines[LINE_BLOFF] = 1'b0;
                KIND_BL_OFF:
                    lines[LINE_BLOFF] = 1'b1;
                KIND_SET_CLK, KIND_QUERY:
                begin
                    idx = nearest_entry(it.clock_khz);
                    near = CLK_KHZ[idx];
                    if (it.kind == KIND_SET_CLK)
                    begin
                        if (REQ_W'(near) != it.clock_khz)
                            st = ST_INEXACT;
                        else
                            pll = CLK_CODE[idx];
                    end
                end
                default:
                    ;
            endcase
        end
        r.lvds_on           = lines[LINE_LVDS];
        r.panel_pwr         = lines[LINE_PANEL];
        r.bl_dark           = lines[LINE_BLOFF];
        r.clock_code        = pll;
        r.nearest_clock_khz = near;
        r.status            = st;
        r.busy_res          = (seq != SEQ_IDLE);
        return r;
    endfunction

    task automatic check_field(input string name, input int e, input int a);
        if (e != a)
        begin
            $display("%0t mismatch %s expected %0h actual %0h", $time, name, e, a);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lines     = LINES_RESET;
            pll       = CODE_RESET;
            seq       = SEQ_IDLE;
            wait_left = '0;
            delay     = DELAY_RESET;
            expected_results.delete();
            errors    = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == DELAY_ADDR)
                delay = pwdata[DELAY_W-1:0];
            if (item_valid && item_ready)
                expected_results.push_back(predict_panel_state(item));
            if (result_valid && result_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t unexpected result transaction expected none actual %0h",
                             $time, result);
                    errors++;
                end
                else
                begin
                    exp_res = expected_results.pop_front();
                    check_field("lvds_on", exp_res.lvds_on, result.lvds_on);
                    check_field("panel_pwr", exp_res.panel_pwr, result.panel_pwr);
                    check_field("bl_dark", exp_res.bl_dark, result.bl_dark);
                    check_field("clock_code", exp_res.clock_code, result.clock_code);
                    check_field("nearest_clock_khz", exp_res.nearest_clock_khz,
                                result.nearest_clock_khz);
                    check_field("status", exp_res.status, result.status);
                    check_field("busy_res", exp_res.busy_res, result.busy_res);
                end
            end
        end
        fail_count  <= errors;
        outstanding <= expected_results.size();
    end

endmodule

/* test/panel_power_and_pixel_clock_sequencer_tb.sv */
// testbench top for the panel power and pixel clock sequencer: stimulus, apb writes and verdict
// depends on ppcs_pkg, ppcs_checker and the block itself
module panel_power_and_pixel_clock_sequencer_tb;
    import ppcs_pkg::*;

    localparam int HOLD_CYCLES = 300;
    localparam logic [PADDR_W-1:0] DELAY_ADDR = {REG_DELAY, 2'b00};

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               item_valid = 1'b0;
    logic               item_ready;
    item_t              item = '0;
    logic               result_valid;
    logic               result_ready = 1'b0;
    result_t            result;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    int                 fail_count;
    int                 outstanding;
    int                 send_idle = 0;
    int                 recv_idle = 0;
    bit                 hold_req = 1'b0;

    panel_power_and_pixel_clock_sequencer u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    ppcs_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .fail_count   (fail_count),
        .outstanding  (outstanding)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #8000000;
        $display("*** FAILED ***");
        $finish;
    end

    // receiver side, with one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                result_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
                result_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    task automatic send_cmd(input kind_t k, input logic [REQ_W-1:0] khz);
        while ($urandom_range(99) < send_idle)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= '{kind: k, clock_khz: khz};
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic write_delay(input logic [DELAY_W-1:0] d);
        drain();
        repeat (4) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= DELAY_ADDR;
        pwdata  <= {{(PDATA_W-DELAY_W){1'b0}}, d};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic [REQ_W-1:0] pick_clock();
        int sel;
        int i;
        int v;
        sel = $urandom_range(99);
        i = $urandom_range(TABLE_LEN - 1);
        if (sel < 45)
            v = int'(CLK_KHZ[i]);
        else if (sel < 65)
            v = int'(CLK_KHZ[i]) + int'($urandom_range(6)) - 3;
        else if (sel < 80)
        begin
            i = $urandom_range(TABLE_LEN - 2);
            v = (int'(CLK_KHZ[i]) + int'(CLK_KHZ[i + 1])) / 2;
        end
        else
            v = $urandom_range(262143);
        return v[REQ_W-1:0];
    endfunction

    function automatic kind_t pick_kind();
        int sel;
        sel = $urandom_range(99);
        if (sel < 45)
            return KIND_TICK;
        else if (sel < 55)
            return KIND_PANEL_ON;
        else if (sel < 63)
            return KIND_PANEL_OFF;
        else if (sel < 69)
            return KIND_BL_ON;
        else if (sel < 75)
            return KIND_BL_OFF;
        else if (sel < 90)
            return KIND_SET_CLK;
        return KIND_QUERY;
    endfunction

    // some power sequences followed by a random burst of mostly ticks, the rest random commands
    task automatic run_random(input logic [DELAY_W-1:0] d, input int n);
        int sent;
        int burst;
        bit paused;
        write_delay(d);
        sent = 0;
        paused = 1'b0;
        while (sent < n)
        begin
            if (!paused && sent >= n / 2)
            begin
                drain();
                paused = 1'b1;
            end
            if ($urandom_range(99) < 30)
            begin
                send_cmd($urandom_range(1) ? KIND_PANEL_ON : KIND_PANEL_OFF,
                         REQ_W'($urandom_range(262143)));
                sent++;
                burst = $urandom_range(2 * int'(d) + 2);
                for (int i = 0; i < burst; i++)
                begin
                    send_cmd(($urandom_range(9) == 0) ? pick_kind() : KIND_TICK,
                             ($urandom_range(1) ? pick_clock()
                                                : REQ_W'($urandom_range(262143))));
                    sent++;
                end
            end
            else
            begin
                send_cmd(pick_kind(), pick_clock());
                sent++;
            end
        end
    endtask

    // longest delay, with the receiver held off while items keep coming
    task automatic run_long_delay();
        write_delay(16'hffff);
        hold_req = 1'b1;
        send_cmd(KIND_PANEL_ON, REQ_W'($urandom_range(262143)));
        for (int i = 0; i < 40; i++)
        begin
            if (i % 8 == 5)
                send_cmd(pick_kind(), pick_clock());
            else
                send_cmd(KIND_TICK, REQ_W'($urandom_range(262143)));
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_delay(16'd2);
        send_cmd(KIND_QUERY, 18'd0);
        send_cmd(KIND_QUERY, 18'd262143);
        send_cmd(KIND_SET_CLK, 18'd0);
        send_cmd(KIND_SET_CLK, 18'd262143);
        send_cmd(KIND_SET_CLK, 18'd120000);
        send_cmd(KIND_SET_CLK, 18'd6750);
        send_cmd(KIND_SET_CLK, 18'd10125);
        send_cmd(KIND_QUERY, 18'd28350);
        send_cmd(KIND_SET_CLK, 18'd54000);
        send_cmd(KIND_BL_ON, 18'd0);
        send_cmd(KIND_BL_OFF, 18'd0);
        send_cmd(KIND_PANEL_OFF, 18'd0);
        send_cmd(KIND_PANEL_ON, 18'd0);
        send_cmd(KIND_SET_CLK, 18'd37125);
        send_cmd(KIND_TICK, 18'd0);
        send_cmd(KIND_TICK, 18'd262143);
        send_cmd(KIND_PANEL_OFF, 18'd0);
        send_cmd(KIND_QUERY, 18'd74250);
        send_cmd(KIND_TICK, 18'd0);
        send_cmd(KIND_TICK, 18'd0);
        send_cmd(KIND_PANEL_ON, 18'd0);
        send_cmd(KIND_TICK, 18'd0);
        send_cmd(KIND_PANEL_OFF, 18'd0);
        send_cmd(KIND_TICK, 18'd0);
        send_cmd(KIND_TICK, 18'd0);
        // zero delay does each step at once
        write_delay(16'd0);
        send_cmd(KIND_PANEL_ON, 18'd0);
        send_cmd(KIND_PANEL_OFF, 18'd0);
        send_cmd(KIND_PANEL_ON, 18'd0);

        send_idle = 31;
        recv_idle = 85;
        run_random(16'd3, 200);
        run_random(16'd1, 170);

        send_idle = 85;
        recv_idle = 31;
        run_random(16'd0, 180);
        run_random(16'd4, 190);

        send_idle = 0;
        recv_idle = 0;
        run_random(16'd2, 190);
        run_random(16'd10, 170);
        run_long_delay();

        drain();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
